>>> rtl/session_table_with_aging_assert.svh
// Assertion macros for the session table.
`ifndef SESSION_TABLE_WITH_AGING_ASSERT_SVH
`define SESSION_TABLE_WITH_AGING_ASSERT_SVH
`ifndef SYNTH
`define STA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define STA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define STA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define STA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sta_pkg.sv
// Package with types and constants of the session table.
`default_nettype none
package sta_pkg;
    localparam int TableDepth = 32;
    localparam int SlotW = $clog2(TableDepth);
    localparam int SubW = 50;
    localparam int AgeW = 16;
    localparam int NumBlack = 6;

    typedef logic [SubW-1:0] sub_t;
    typedef logic [AgeW-1:0] age_t;
    typedef logic [SlotW-1:0] slot_t;

    typedef enum logic [1:0] {OP_CREATE, OP_QUERY, OP_TICK, OP_SHUTDOWN} op_t;
    typedef enum logic [2:0] {
        ST_CREATED, ST_BLACKLISTED, ST_EXISTS, ST_FULL,
        ST_ACTIVE, ST_INACTIVE, ST_EXPIRED, ST_SHUTDOWN
    } status_t;
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

    typedef enum logic [2:0] {
        REG_TIMEOUT, REG_BCOUNT, REG_BL0, REG_BL1, REG_BL2, REG_BL3, REG_BL4, REG_BL5
    } reg_idx_t;

    // Control handed to every cell in one cycle.
    typedef struct packed {
        logic  lookup;   // lookup flag, unused: cells always compare key against held entry
        logic  write;    // write key into the selected cell
        slot_t wslot;
        logic  age;      // age all valid entries this cycle
        logic  kill;     // clear the selected cell
        slot_t kslot;
        age_t  timeout;
    } cell_ctl_t;
endpackage
`default_nettype wire

>>> rtl/session_table_with_aging.sv
// Top level of the session table with idle-timeout aging.
//
// A row of TableDepth cells each holds one session and compares it with the
// key broadcast to all of them. A create or query is compared in the cycle after
// acceptance, during which the priority pick is made and the single result is
// loaded into the output register, from which the result transfer is offered.
// The input is ready whenever the control is idle, so a new item is accepted
// only after the previous one has loaded its result. A result still waiting in
// the output register holds a following create or query in its compare cycle
// until the register frees.
// A tick ages all valid cells in its first cycle after acceptance. A scan then
// walks the slots in ascending order, one slot per cycle while no reporting slot
// waits on the output, and issues an expired transfer for each aged-out slot. A
// shutdown scans in the same way, issuing a shutdown transfer for each held
// slot, after passing through the compare state. The scan stops at the last
// slot that reports, and the input reopens once the last result is loaded.
// Configuration is written over APB, one 64-bit register every eight bytes, and
// only while no item is in flight; the user must ensure it, the block does not.
`default_nettype none
module session_table_with_aging
    import sta_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // op[1:0], subscriber[51:2], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // status[2:0], session_id[52:3], zero pad
    output logic             m_tlast
);
    `include "session_table_with_aging_assert.svh"

    age_t   timeout_reg;
    logic [2:0] bcount_reg;
    sub_t   black_reg [NumBlack];

    state_t state_reg, state_next;
    op_t    op_reg;
    sub_t   key_reg;
    slot_t  scan_reg, scan_next;
    logic   first_reg;

    logic   ovalid_reg;
    logic [2:0] ostat_reg;
    sub_t   osub_reg;
    logic   olast_reg;

    cell_ctl_t ctl;
    logic [TableDepth-1:0] vv, hv, ev;
    sub_t   subs [TableDepth];

    logic   wr_en;
    reg_idx_t widx;
    logic   in_acc;

    assign pready = 1'b1;
    assign widx = reg_idx_t'(paddr[5:3]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= age_t'(30);
            bcount_reg <= '0;
            for (int i = 0; i < NumBlack; i++)
            begin
                black_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            case (widx)
                REG_TIMEOUT: timeout_reg <= pwdata[AgeW-1:0];
                REG_BCOUNT:  bcount_reg <= pwdata[2:0];
                default:     black_reg[3'(widx) - 3'd2] <= pwdata[SubW-1:0];
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_TIMEOUT: prdata = 64'(timeout_reg);
            REG_BCOUNT:  prdata = 64'(bcount_reg);
            default:     prdata = 64'(black_reg[3'(widx) - 3'd2]);
        endcase
    end

    // The cell row.
    for (genvar g = 0; g < TableDepth; g++)
    begin : g_cell
        sta_cell u_cell (
            .clk(clk), .rst_n(rst_n), .idx(slot_t'(g)), .ctl(ctl), .key(key_reg),
            .valid(vv[g]), .hit(hv[g]), .expire(ev[g]), .sub(subs[g])
        );
    end

    // Blacklist match and lowest free slot.
    logic  black_hit;
    logic  has_free;
    slot_t free_slot;
    always_comb
    begin
        black_hit = 1'b0;
        for (int i = 0; i < NumBlack; i++)
        begin
            if (3'(i) < bcount_reg && black_reg[i] == key_reg)
            begin
                black_hit = 1'b1;
            end
        end
        has_free = 1'b0;
        free_slot = '0;
        for (int i = TableDepth - 1; i >= 0; i--)
        begin
            if (!vv[i])
            begin
                has_free = 1'b1;
                free_slot = slot_t'(i);
            end
        end
    end

    // Does any remaining slot above the scan point still produce a result?
    logic scan_take;
    logic more_after;
    always_comb
    begin
        scan_take = (op_reg == OP_TICK) ? ev[scan_reg] : vv[scan_reg];
        more_after = 1'b0;
        for (int i = 0; i < TableDepth; i++)
        begin
            if (slot_t'(i) > scan_reg && ((op_reg == OP_TICK) ? ev[i] : vv[i]))
            begin
                more_after = 1'b1;
            end
        end
    end

    assign in_acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    logic out_free;
    assign out_free = !ovalid_reg || m_tready;

    logic ld;
    logic [2:0] ld_stat;
    logic ld_last;
    always_comb
    begin
        state_next = state_reg;
        scan_next = scan_reg;
        ctl = '0;
        ctl.timeout = timeout_reg;
        ld = 1'b0;
        ld_stat = ST_CREATED;
        ld_last = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_SCAN;
                    scan_next = '0;
                end
            end
            S_SCAN:
            begin
                case (op_reg)
                    OP_CREATE:
                    begin
                        if (out_free)
                        begin
                            ld = 1'b1;
                            state_next = S_IDLE;
                            if (black_hit) ld_stat = ST_BLACKLISTED;
                            else if (|hv) ld_stat = ST_EXISTS;
                            else if (!has_free) ld_stat = ST_FULL;
                            else
                            begin
                                ld_stat = ST_CREATED;
                                ctl.write = 1'b1;
                                ctl.wslot = free_slot;
                            end
                        end
                    end
                    OP_QUERY:
                    begin
                        if (out_free)
                        begin
                            ld = 1'b1;
                            state_next = S_IDLE;
                            ld_stat = (|hv) ? ST_ACTIVE : ST_INACTIVE;
                        end
                    end
                    OP_TICK:
                    begin
                        ctl.age = 1'b1;
                        state_next = S_OUT;
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_OUT:
            begin
                if (out_free || !scan_take)
                begin
                    ld_stat = (op_reg == OP_TICK) ? ST_EXPIRED : ST_SHUTDOWN;
                    ld_last = !more_after;
                    if (scan_take)
                    begin
                        ld = 1'b1;
                        ctl.kill = 1'b1;
                        ctl.kslot = scan_reg;
                    end
                    if (!more_after)
                    begin
                        state_next = S_IDLE;
                    end
                    scan_next = scan_reg + slot_t'(1);
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovalid_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= in_acc;
            if (ld) ovalid_reg <= 1'b1;
            else if (m_tready) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        if (in_acc)
        begin
            op_reg <= op_t'(s_tdata[1:0]);
            key_reg <= s_tdata[51:2];
        end
        if (ld)
        begin
            ostat_reg <= ld_stat;
            olast_reg <= ld_last;
            osub_reg <= (state_reg == S_OUT) ? subs[scan_reg] : key_reg;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata = {3'b000, osub_reg, ostat_reg};
    assign m_tlast = olast_reg;

    `STA_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !s_tready)
    `STA_ASSERT_NEXT(a_acc_scan, clk, rst_n, in_acc, state_reg == S_SCAN)
    `STA_ASSERT_IMPL(a_first_scan, clk, rst_n, first_reg, state_reg == S_SCAN)
endmodule
`default_nettype wire

>>> rtl/sta_cell.sv
// One table slot: holds a subscriber and its age, compares and ages.
`default_nettype none
module sta_cell
    import sta_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire slot_t     idx,
    input  wire cell_ctl_t ctl,
    input  wire sub_t      key,
    output logic           valid,
    output logic           hit,
    output logic           expire,
    output sub_t           sub
);
    logic valid_reg;
    sub_t sub_reg;
    age_t age_reg;
    age_t age_inc;

    assign valid = valid_reg;
    assign sub = sub_reg;
    assign hit = valid_reg && (sub_reg == key);
    assign age_inc = (age_reg == '1) ? age_reg : age_reg + age_t'(1);
    // Expiry flag is judged after aging, as seen in the following cycle.
    assign expire = valid_reg && (age_reg > ctl.timeout);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.write && ctl.wslot == idx)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctl.kill && ctl.kslot == idx)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write && ctl.wslot == idx)
        begin
            sub_reg <= key;
            age_reg <= '0;
        end
        else if (ctl.age && valid_reg)
        begin
            age_reg <= age_inc;
        end
    end
endmodule
`default_nettype wire

>>> tb/session_table_with_aging_test.sv
// Self-checking testbench for the session table with idle-timeout aging.
`default_nettype none
module session_table_with_aging_test;
    import sta_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Input transfer: operation and subscriber number.
    typedef struct {
        op_t  op;
        sub_t subscriber;
    } request_t;

    // Result transfer as the block should present it.
    typedef struct {
        status_t status;
        sub_t    session_id;
        logic    last;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // op[1:0], subscriber[51:2], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // status[2:0], session_id[52:3], zero pad
    logic        m_tlast;

    session_table_with_aging DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    // Predictor state: the table contents and the configuration as they
    // stand after every request accepted so far.
    logic          slot_used [TableDepth];
    sub_t          slot_sub  [TableDepth];
    age_t          slot_age  [TableDepth];
    age_t          timeout_ticks;
    logic [2:0]    deny_count;
    sub_t          deny_list [NumBlack];

    request_t      pending_requests[$];
    outcome_t      expected_outcomes[$];

    int            send_idle_pct;
    int            recv_stall_pct;
    bit            failed;
    bit            in_taken;
    longint        cycle_count;
    longint        transfers_seen;

    localparam longint CycleLimit = 2_000_000;
    localparam longint PoolSize = 12;

    sub_t          id_pool[PoolSize];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies a register write to the predictor.
    function automatic void model_config(reg_idx_t idx, logic [63:0] value);
        case (idx)
            REG_TIMEOUT: timeout_ticks = value[AgeW-1:0];
            REG_BCOUNT:  deny_count = value[2:0];
            default:     deny_list[int'(idx) - int'(REG_BL0)] = value[SubW-1:0];
        endcase
    endfunction

    function automatic bit is_denied(sub_t id);
        int limit;
        limit = (deny_count > NumBlack) ? NumBlack : deny_count;
        for (int i = 0; i < limit; i++)
            if (deny_list[i] == id)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic int slot_of(sub_t id);
        for (int i = 0; i < TableDepth; i++)
            if (slot_used[i] && slot_sub[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void push_outcome(status_t st, sub_t id);
        outcome_t o;
        o.status = st;
        o.session_id = id;
        o.last = 1'b0;
        expected_outcomes.insert(expected_outcomes.size(), o);
    endfunction

    // Works out every result caused by one accepted request and updates
    // the predicted table. The last result of a request carries last.
    function automatic void predict_session(request_t rq);
        int before_count;
        int free_slot;
        before_count = expected_outcomes.size();
        free_slot = -1;
        case (rq.op)
            OP_CREATE:
            begin
                if (is_denied(rq.subscriber))
                    push_outcome(ST_BLACKLISTED, rq.subscriber);
                else if (slot_of(rq.subscriber) >= 0)
                    push_outcome(ST_EXISTS, rq.subscriber);
                else
                begin
                    for (int i = 0; i < TableDepth; i++)
                        if (!slot_used[i] && free_slot < 0)
                            free_slot = i;
                    if (free_slot < 0)
                        push_outcome(ST_FULL, rq.subscriber);
                    else
                    begin
                        slot_used[free_slot] = 1'b1;
                        slot_sub[free_slot] = rq.subscriber;
                        slot_age[free_slot] = '0;
                        push_outcome(ST_CREATED, rq.subscriber);
                    end
                end
            end
            OP_QUERY:
                push_outcome((slot_of(rq.subscriber) >= 0) ? ST_ACTIVE : ST_INACTIVE,
                             rq.subscriber);
            OP_TICK:
                for (int i = 0; i < TableDepth; i++)
                begin
                    if (slot_used[i])
                    begin
                        // The age saturates rather than wrapping.
                        if (slot_age[i] != '1)
                            slot_age[i] = slot_age[i] + age_t'(1);
                        if (slot_age[i] > timeout_ticks)
                        begin
                            slot_used[i] = 1'b0;
                            push_outcome(ST_EXPIRED, slot_sub[i]);
                        end
                    end
                end
            default:
                for (int i = 0; i < TableDepth; i++)
                begin
                    if (slot_used[i])
                    begin
                        slot_used[i] = 1'b0;
                        push_outcome(ST_SHUTDOWN, slot_sub[i]);
                    end
                end
        endcase
        if (expected_outcomes.size() > before_count)
            expected_outcomes[expected_outcomes.size() - 1].last = 1'b1;
    endfunction

    // Driver: offers queued requests, with random gaps. tvalid stays up
    // until the transfer happens, and the next request follows straight on
    // when no gap is drawn. The monitor removes a request from the queue at
    // the edge that transfers it.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((!s_tvalid || in_taken) && pending_requests.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= {4'b0, pending_requests[0].subscriber, pending_requests[0].op};
            end
            else if (!s_tvalid || in_taken)
                s_tvalid <= 1'b0;
            in_taken = 1'b0;
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: updates the predictor on each accepted request and checks
    // each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t want;
        request_t rq;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (s_tvalid && s_tready)
            begin
                rq.op = op_t'(s_tdata[1:0]);
                rq.subscriber = s_tdata[51:2];
                predict_session(rq);
                void'(pending_requests.pop_front());
                in_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                transfers_seen <= transfers_seen + 1;
                if (expected_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual status %0d id %0d last %0b",
                             $time, m_tdata[2:0], m_tdata[52:3], m_tlast);
                    failed <= 1'b1;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (m_tdata[2:0] !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, m_tdata[2:0]);
                        failed <= 1'b1;
                    end
                    if (m_tdata[52:3] !== want.session_id)
                    begin
                        $display("%0t: session id mismatch: expected %0d, actual %0d",
                                 $time, want.session_id, m_tdata[52:3]);
                        failed <= 1'b1;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, m_tlast);
                        failed <= 1'b1;
                    end
                    if (m_tdata[55:53] !== 3'b0)
                    begin
                        $display("%0t: padding mismatch: expected 0, actual %0h",
                                 $time, m_tdata[55:53]);
                        failed <= 1'b1;
                    end
                end
            end
        end
    end

    // Watchdog on the overall run length.
    always @(posedge clk)
    begin
        if (cycle_count > CycleLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Register write over APB: setup cycle then access cycle, changing
    // signals on the falling edge.
    task automatic write_register(reg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(int'(idx) * 8);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        model_config(idx, value);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Waits until every queued request is sent and every result has come,
    // then a settling margin covering a full scan with nothing to report.
    task automatic drain_block();
        while (pending_requests.size() > 0 || s_tvalid || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (TableDepth + 8) @(posedge clk);
    endtask

    function automatic sub_t random_subscriber();
        logic [63:0] v;
        case ($urandom_range(3))
            0: v = 64'h3_8D7E_A4C6_7FFF;                 // largest 15-digit value
            1: v = 64'($urandom_range(9));
            default: v = {$urandom, $urandom} % 64'd1_000_000_000_000_000;
        endcase
        return v[SubW-1:0];
    endfunction

    function automatic void queue_request(op_t op, sub_t id);
        request_t rq;
        rq.op = op;
        rq.subscriber = id;
        pending_requests.insert(pending_requests.size(), rq);
    endfunction

    // Mostly well-formed traffic over a small pool of numbers so that
    // duplicates, queries of live sessions and expiry all occur often.
    task automatic queue_random_phase(int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                queue_request(OP_CREATE, id_pool[$urandom_range(PoolSize - 1)]);
            else if (pick < 55)
                queue_request(OP_CREATE, random_subscriber());
            else if (pick < 75)
                queue_request(OP_QUERY, id_pool[$urandom_range(PoolSize - 1)]);
            else if (pick < 97)
                queue_request(OP_TICK, random_subscriber());
            else
                queue_request(OP_SHUTDOWN, random_subscriber());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        failed = 1'b0;
        in_taken = 1'b0;
        cycle_count = 0;
        transfers_seen = 0;
        timeout_ticks = 16'd30;
        deny_count = '0;
        for (int i = 0; i < NumBlack; i++)
            deny_list[i] = '0;
        for (int i = 0; i < TableDepth; i++)
        begin
            slot_used[i] = 1'b0;
            slot_sub[i] = '0;
            slot_age[i] = '0;
        end
        for (int i = 0; i < PoolSize; i++)
            id_pool[i] = random_subscriber();
        id_pool[0] = 50'h3_8D7E_A4C6_7FFF;
        id_pool[1] = '0;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed part at reset configuration: blacklist count of zero means
        // nothing is refused, even number zero that the blacklist holds.
        queue_request(OP_SHUTDOWN, '0);                  // empty table, no result
        queue_request(OP_TICK, '1);                      // nothing to expire
        queue_request(OP_CREATE, '0);
        queue_request(OP_CREATE, 50'h3_8D7E_A4C6_7FFF);
        queue_request(OP_CREATE, '0);                    // already has a session
        queue_request(OP_QUERY, '0);
        queue_request(OP_QUERY, 50'h1_5555_5555_5555);   // no session
        queue_request(OP_SHUTDOWN, 50'h2_AAAA_AAAA_AAAA);
        drain_block();

        // Timeout zero with a full blacklist; the count register is written
        // with seven, which counts as six.
        write_register(REG_TIMEOUT, 64'd0);
        for (int i = 0; i < NumBlack; i++)
            write_register(reg_idx_t'(int'(REG_BL0) + i), 64'(id_pool[i]));
        write_register(REG_BCOUNT, 64'd7);
        queue_request(OP_CREATE, id_pool[5]);           // refused: blacklisted
        queue_request(OP_CREATE, id_pool[7]);
        queue_request(OP_TICK, '0);                      // expires at once
        // Fill the table, then one more is refused as full.
        for (int i = 0; i < TableDepth; i++)
            queue_request(OP_CREATE, 50'(1000 + i));
        queue_request(OP_CREATE, 50'd5000);
        queue_request(OP_TICK, '0);                      // all 32 expire in one tick
        drain_block();

        // Largest timeout: nothing ever expires.
        write_register(REG_TIMEOUT, 64'hFFFF);
        write_register(REG_BCOUNT, 64'd2);
        queue_request(OP_CREATE, id_pool[9]);
        queue_request(OP_TICK, '0);
        queue_request(OP_QUERY, id_pool[9]);
        queue_request(OP_SHUTDOWN, '0);
        drain_block();

        // Random phases under the four handshake pressure settings, each with
        // its own configuration.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            write_register(REG_TIMEOUT, 64'($urandom_range(6)));
            write_register(REG_BCOUNT, 64'($urandom_range(7)));
            write_register(reg_idx_t'(int'(REG_BL0) + $urandom_range(NumBlack - 1)),
                           64'(id_pool[$urandom_range(PoolSize - 1)]));
            queue_random_phase(20);
            // Hold the sender back until the block has caught up.
            drain_block();
            queue_random_phase(20);
            drain_block();
        end
        write_register(REG_TIMEOUT, 64'd65534);
        queue_request(OP_CREATE, id_pool[11]);
        queue_request(OP_TICK, '0);
        queue_request(OP_SHUTDOWN, '0);
        drain_block();

        if (!failed && expected_outcomes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
